>>> rtl/core/sha1_pkg.sv
// ============================================================================
// SHA-1 message hash package
// Shared types, constants and control bundles for the SHA-1 hash core.
// ============================================================================
`default_nettype none

package sha1_pkg;

    // Block geometry: sixteen 32-bit words per 64-byte block.
    localparam int BLOCK_WORDS = 16;
    localparam int WIDX_W      = $clog2(BLOCK_WORDS);
    localparam int ROUNDS      = 80;
    localparam int ROUND_W     = $clog2(ROUNDS);
    localparam int BYTE_CNT_W  = 61;

    // Word positions of the appended bit length.
    localparam logic [WIDX_W-1:0] LEN_HI_IDX = 4'd14;
    localparam logic [WIDX_W-1:0] LEN_LO_IDX = 4'd15;
    localparam logic [WIDX_W-1:0] LAST_IDX   = 4'd15;

    // Last round of the compression.
    localparam logic [ROUND_W-1:0] LAST_ROUND = 7'd79;

    // Digest word numbering.
    localparam logic [2:0] DIGEST_LAST = 3'd4;

    // Initial chaining values.
    localparam logic [4:0][31:0] INIT_WORDS = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    // Round constants.
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    // Padding marker byte.
    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Input word.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       is_last;
    } msg_word_t;

    // Output word.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_word_t;

    // Sequencer states.
    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_PRIME     = 7'b0000010,
        ST_ROUND     = 7'b0000100,
        ST_ADD       = 7'b0001000,
        ST_PAD_FIRST = 7'b0010000,
        ST_PAD_FILL  = 7'b0100000,
        ST_EMIT      = 7'b1000000
    } state_t;

    // Control for the schedule memories.
    typedef struct packed {
        logic               load;
        logic [WIDX_W-1:0]  load_idx;
        logic [31:0]        load_word;
        logic               prime;
        logic               round;
        logic [ROUND_W-1:0] t;
    } sched_ctl_t;

    // Control for the round datapath.
    typedef struct packed {
        logic               init;
        logic               start;
        logic               round;
        logic               add;
        logic [ROUND_W-1:0] t;
    } round_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/sha1_ram.sv
// ============================================================================
// Generic synchronous RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module sha1_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/core/sha1_sched.sv
// ============================================================================
// SHA-1 message schedule
// Two 16-entry memories hold the block words w[j] and the pair sums
// w[j] ^ w[j-2]; a three-word window supplies w[t-3] for the expansion.
// ============================================================================
`default_nettype none

module sha1_sched (
    input  wire logic                clk,
    input  wire sha1_pkg::sched_ctl_t ctl,
    output logic [31:0]              w
);

    localparam int AW = sha1_pkg::WIDX_W;

    logic [31:0]            win_reg [3];
    logic [31:0]            win_next [3];
    logic [31:0]            rd_w;
    logic [31:0]            rd_p;
    logic [sha1_pkg::ROUND_W-1:0] tn;
    logic [AW-1:0]          raddr_w;
    logic [AW-1:0]          raddr_p;
    logic                   we;
    logic [AW-1:0]          waddr;
    logic [31:0]            wdata_w;
    logic [31:0]            wdata_p;
    logic                   expand;

    // Expanded word of the current round; the first sixteen come straight
    // from the block.
    assign expand = (ctl.t >= sha1_pkg::ROUND_W'(sha1_pkg::BLOCK_WORDS));
    always_comb
    begin
        logic [31:0] x;
        x = win_reg[2] ^ rd_w ^ rd_p;
        if (expand)
        begin
            w = {x[30:0], x[31]};
        end
        else
        begin
            w = rd_w;
        end
    end

    // Read addresses for the next round: w[t-8] and the pair sum at t-14.
    always_comb
    begin
        if (ctl.prime)
        begin
            tn = '0;
        end
        else
        begin
            tn = ctl.t + sha1_pkg::ROUND_W'(1);
        end
        if (tn < sha1_pkg::ROUND_W'(sha1_pkg::BLOCK_WORDS))
        begin
            raddr_w = tn[AW-1:0];
        end
        else
        begin
            raddr_w = tn[AW-1:0] + AW'(8);
        end
        raddr_p = tn[AW-1:0] + AW'(2);
    end

    // Write port: block words while loading, expanded words during rounds.
    always_comb
    begin
        we      = 1'b0;
        waddr   = ctl.load_idx;
        wdata_w = ctl.load_word;
        for (int i = 0; i < 3; i++)
        begin
            win_next[i] = win_reg[i];
        end
        if (ctl.load)
        begin
            we          = 1'b1;
            win_next[0] = ctl.load_word;
            win_next[1] = win_reg[0];
            win_next[2] = win_reg[1];
        end
        else if (ctl.round)
        begin
            we          = expand;
            waddr       = ctl.t[AW-1:0];
            wdata_w     = w;
            win_next[0] = w;
            win_next[1] = win_reg[0];
            win_next[2] = win_reg[1];
        end
        wdata_p = wdata_w ^ win_reg[1];
    end

    // Window of the three most recent words.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_reg[i] <= win_next[i];
        end
    end

    sha1_ram #(
        .WIDTH (32),
        .DEPTH (sha1_pkg::BLOCK_WORDS)
    ) u_word_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata_w),
        .raddr (raddr_w),
        .rdata (rd_w)
    );

    sha1_ram #(
        .WIDTH (32),
        .DEPTH (sha1_pkg::BLOCK_WORDS)
    ) u_pair_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata_p),
        .raddr (raddr_p),
        .rdata (rd_p)
    );

endmodule

`default_nettype wire

>>> rtl/core/sha1_round.sv
// ============================================================================
// SHA-1 round datapath
// Holds the chaining words and the five round variables and performs one
// round per cycle.
// ============================================================================
`default_nettype none

module sha1_round (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire sha1_pkg::round_ctl_t ctl,
    input  wire logic [31:0]         w,
    output logic [4:0][31:0]         chain
);

    logic [4:0][31:0] chain_reg;
    logic [4:0][31:0] chain_next;
    logic [4:0][31:0] var_reg;
    logic [4:0][31:0] var_next;
    logic [31:0]      f;
    logic [31:0]      k;
    logic [31:0]      tmp;

    assign chain = chain_reg;

    // Round function and constant by round group.
    always_comb
    begin
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        b = var_reg[1];
        c = var_reg[2];
        d = var_reg[3];
        priority if (ctl.t < 7'd20)
        begin
            f = (b & c) | (~b & d);
            k = sha1_pkg::K0;
        end
        else if (ctl.t < 7'd40)
        begin
            f = b ^ c ^ d;
            k = sha1_pkg::K1;
        end
        else if (ctl.t < 7'd60)
        begin
            f = (b & c) | (b & d) | (c & d);
            k = sha1_pkg::K2;
        end
        else
        begin
            f = b ^ c ^ d;
            k = sha1_pkg::K3;
        end
        tmp = {var_reg[0][26:0], var_reg[0][31:27]} + f + var_reg[4] + k + w;
    end

    // Next values of the round variables and the chaining words.
    always_comb
    begin
        var_next   = var_reg;
        chain_next = chain_reg;
        if (ctl.start)
        begin
            var_next = chain_reg;
        end
        else if (ctl.round)
        begin
            var_next[4] = var_reg[3];
            var_next[3] = var_reg[2];
            var_next[2] = {var_reg[1][1:0], var_reg[1][31:2]};
            var_next[1] = var_reg[0];
            var_next[0] = tmp;
        end
        if (ctl.init)
        begin
            chain_next = sha1_pkg::INIT_WORDS;
        end
        else if (ctl.add)
        begin
            for (int i = 0; i < 5; i++)
            begin
                chain_next[i] = chain_reg[i] + var_reg[i];
            end
        end
    end

    // Chaining words start from the initial values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= sha1_pkg::INIT_WORDS;
        end
        else
        begin
            chain_reg <= chain_next;
        end
    end

    // Working variables need no reset.
    always_ff @(posedge clk)
    begin
        var_reg <= var_next;
    end

endmodule

`default_nettype wire

>>> rtl/core/sha1_message_hash_core.sv
// ============================================================================
// SHA-1 message hash core
// Takes a message one byte per word, pads it and returns the five digest
// words after the word marked last.
// ============================================================================
// A byte is taken while the core is idle; a full block then stalls the input through
// the prime state (the memory read-ahead), the rounds and the add. The last word adds
// the padding loads and the rounds for each of the one or two blocks left, then five
// digest words follow, one per cycle while digest_stall is low. Reset loads the initial
// chaining values and clears the length; the schedule memories are not cleared.
`default_nettype none

module sha1_message_hash_core (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   msg_valid,
    output logic                        msg_stall,
    input  wire sha1_pkg::msg_word_t    msg,
    output logic                        digest_valid,
    input  wire logic                   digest_stall,
    output sha1_pkg::digest_word_t      digest
);

    localparam int AW = sha1_pkg::WIDX_W;

    sha1_pkg::state_t                 state_reg;
    sha1_pkg::state_t                 state_next;
    logic [sha1_pkg::BYTE_CNT_W-1:0]  byte_cnt_reg;
    logic [sha1_pkg::BYTE_CNT_W-1:0]  byte_cnt_next;
    logic [31:0]                      word_reg;
    logic [31:0]                      word_next;
    logic [sha1_pkg::ROUND_W-1:0]     t_reg;
    logic [sha1_pkg::ROUND_W-1:0]     t_next;
    logic [AW-1:0]                    idx_reg;
    logic [AW-1:0]                    idx_next;
    logic [2:0]                       emit_reg;
    logic [2:0]                       emit_next;
    logic                             pad_pending_reg;
    logic                             pad_pending_next;
    logic                             pad_active_reg;
    logic                             pad_active_next;
    logic                             len_in_reg;
    logic                             len_in_next;

    sha1_pkg::sched_ctl_t             sched_ctl;
    sha1_pkg::round_ctl_t             round_ctl;
    logic [31:0]                      w;
    logic [4:0][31:0]                 chain;
    logic                             msg_take;
    logic                             digest_take;
    logic [5:0]                       pos;
    logic [63:0]                      bit_len;
    logic [31:0]                      pad_word;
    logic [31:0]                      fill_word;

    assign msg_stall    = (state_reg != sha1_pkg::ST_IDLE);
    assign msg_take     = msg_valid && !msg_stall;
    assign digest_valid = (state_reg == sha1_pkg::ST_EMIT);
    assign digest_take  = digest_valid && !digest_stall;

    assign pos     = byte_cnt_reg[5:0];
    assign bit_len = {byte_cnt_reg, 3'b000};

    // Digest output straight from the chaining words.
    assign digest.digest_word = chain[emit_reg];
    assign digest.word_index  = emit_reg;
    assign digest.last_word   = (emit_reg == sha1_pkg::DIGEST_LAST);

    // Word holding the 0x80 marker after the bytes of a partial word.
    always_comb
    begin
        unique case (pos[1:0])
            2'd0:    pad_word = {sha1_pkg::PAD_BYTE, 24'h0};
            2'd1:    pad_word = {word_reg[7:0], sha1_pkg::PAD_BYTE, 16'h0};
            2'd2:    pad_word = {word_reg[15:0], sha1_pkg::PAD_BYTE, 8'h0};
            default: pad_word = {word_reg[23:0], sha1_pkg::PAD_BYTE};
        endcase
    end

    // Zero fill, or the bit length in the last two words.
    always_comb
    begin
        fill_word = '0;
        if (len_in_reg && idx_reg == sha1_pkg::LEN_HI_IDX)
        begin
            fill_word = bit_len[63:32];
        end
        else if (len_in_reg && idx_reg == sha1_pkg::LEN_LO_IDX)
        begin
            fill_word = bit_len[31:0];
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next       = state_reg;
        byte_cnt_next    = byte_cnt_reg;
        word_next        = word_reg;
        t_next           = t_reg;
        idx_next         = idx_reg;
        emit_next        = emit_reg;
        pad_pending_next = pad_pending_reg;
        pad_active_next  = pad_active_reg;
        len_in_next      = len_in_reg;

        sched_ctl           = '0;
        sched_ctl.load_idx  = pos[5:2];
        sched_ctl.load_word = {word_reg[23:0], msg.data_byte};
        sched_ctl.t         = t_reg;
        round_ctl           = '0;
        round_ctl.t         = t_reg;

        unique case (state_reg)
            sha1_pkg::ST_IDLE:
            begin
                if (msg_take)
                begin
                    if (msg.byte_present)
                    begin
                        word_next      = {word_reg[23:0], msg.data_byte};
                        byte_cnt_next  = byte_cnt_reg + sha1_pkg::BYTE_CNT_W'(1);
                        sched_ctl.load = (pos[1:0] == 2'd3);
                        if (pos == 6'd63)
                        begin
                            pad_pending_next = msg.is_last;
                            state_next       = sha1_pkg::ST_PRIME;
                        end
                        else if (msg.is_last)
                        begin
                            state_next = sha1_pkg::ST_PAD_FIRST;
                        end
                    end
                    else if (msg.is_last)
                    begin
                        state_next = sha1_pkg::ST_PAD_FIRST;
                    end
                end
            end

            sha1_pkg::ST_PRIME:
            begin
                sched_ctl.prime = 1'b1;
                round_ctl.start = 1'b1;
                t_next          = '0;
                state_next      = sha1_pkg::ST_ROUND;
            end

            sha1_pkg::ST_ROUND:
            begin
                sched_ctl.round = 1'b1;
                round_ctl.round = 1'b1;
                t_next          = t_reg + sha1_pkg::ROUND_W'(1);
                if (t_reg == sha1_pkg::LAST_ROUND)
                begin
                    state_next = sha1_pkg::ST_ADD;
                end
            end

            sha1_pkg::ST_ADD:
            begin
                round_ctl.add = 1'b1;
                priority if (pad_pending_reg)
                begin
                    pad_pending_next = 1'b0;
                    state_next       = sha1_pkg::ST_PAD_FIRST;
                end
                else if (pad_active_reg && len_in_reg)
                begin
                    emit_next  = '0;
                    state_next = sha1_pkg::ST_EMIT;
                end
                else if (pad_active_reg)
                begin
                    len_in_next = 1'b1;
                    idx_next    = '0;
                    state_next  = sha1_pkg::ST_PAD_FILL;
                end
                else
                begin
                    state_next = sha1_pkg::ST_IDLE;
                end
            end

            sha1_pkg::ST_PAD_FIRST:
            begin
                sched_ctl.load      = 1'b1;
                sched_ctl.load_word = pad_word;
                pad_active_next     = 1'b1;
                len_in_next         = (pos[5:2] < sha1_pkg::LEN_HI_IDX);
                idx_next            = pos[5:2] + AW'(1);
                if (pos[5:2] == sha1_pkg::LAST_IDX)
                begin
                    state_next = sha1_pkg::ST_PRIME;
                end
                else
                begin
                    state_next = sha1_pkg::ST_PAD_FILL;
                end
            end

            sha1_pkg::ST_PAD_FILL:
            begin
                sched_ctl.load      = 1'b1;
                sched_ctl.load_idx  = idx_reg;
                sched_ctl.load_word = fill_word;
                idx_next            = idx_reg + AW'(1);
                if (idx_reg == sha1_pkg::LAST_IDX)
                begin
                    state_next = sha1_pkg::ST_PRIME;
                end
            end

            sha1_pkg::ST_EMIT:
            begin
                if (digest_take)
                begin
                    emit_next = emit_reg + 3'd1;
                    if (emit_reg == sha1_pkg::DIGEST_LAST)
                    begin
                        round_ctl.init  = 1'b1;
                        byte_cnt_next   = '0;
                        pad_active_next = 1'b0;
                        len_in_next     = 1'b0;
                        state_next      = sha1_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = sha1_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= sha1_pkg::ST_IDLE;
            byte_cnt_reg    <= '0;
            t_reg           <= '0;
            idx_reg         <= '0;
            emit_reg        <= '0;
            pad_pending_reg <= 1'b0;
            pad_active_reg  <= 1'b0;
            len_in_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            byte_cnt_reg    <= byte_cnt_next;
            t_reg           <= t_next;
            idx_reg         <= idx_next;
            emit_reg        <= emit_next;
            pad_pending_reg <= pad_pending_next;
            pad_active_reg  <= pad_active_next;
            len_in_reg      <= len_in_next;
        end
    end

    // Byte assembly register.
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    sha1_sched u_sched (
        .clk (clk),
        .ctl (sched_ctl),
        .w   (w)
    );

    sha1_round u_round (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (round_ctl),
        .w     (w),
        .chain (chain)
    );

endmodule

`default_nettype wire

>>> bench/sha1_digest_checker.sv
// ============================================================================
// SHA-1 digest checker
// Watches the message and digest channels of the SHA-1 hash core. It keeps
// its own SHA-1 state, predicts the five digest words of every message and
// compares each digest word that the core hands out with the oldest one due.
// ============================================================================

module sha1_digest_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   msg_valid,
    input  logic                   msg_stall,
    input  sha1_pkg::msg_word_t    msg,
    input  logic                   digest_valid,
    input  logic                   digest_stall,
    input  sha1_pkg::digest_word_t digest,
    output int                     mismatches,
    output int                     outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAD_LEN_POS = 56;
    localparam int REPORT_MAX  = 10;

    // Predicted hash state: chaining words, block bytes and message length.
    logic [31:0]            hash_h [5];
    logic [7:0]             block_bytes [64];
    logic [63:0]            msg_bits;
    sha1_pkg::digest_word_t due_digests [$];
    int                     fail_count = 0;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // Back to the start of a fresh message.
    function automatic void load_initial();
        for (int i = 0; i < 5; i++)
            hash_h[i] = sha1_pkg::INIT_WORDS[i];
        msg_bits = '0;
    endfunction

    // Eighty rounds over the current block, folded into the chaining words.
    function automatic void run_rounds();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, wt, tmp;
        int t;
        for (t = 0; t < 16; t++)
            w[t] = {block_bytes[4*t], block_bytes[4*t+1],
                    block_bytes[4*t+2], block_bytes[4*t+3]};
        a = hash_h[0];
        b = hash_h[1];
        c = hash_h[2];
        d = hash_h[3];
        e = hash_h[4];
        for (t = 0; t < 80; t++)
        begin
            if (t < 16)
                wt = w[t];
            else
            begin
                wt = rotl(w[(t+13) & 15] ^ w[(t+8) & 15] ^ w[(t+2) & 15] ^ w[t & 15], 1);
                w[t & 15] = wt;
            end
            if (t < 20)
            begin
                f = (b & c) | (~b & d);
                k = sha1_pkg::K0;
            end
            else if (t < 40)
            begin
                f = b ^ c ^ d;
                k = sha1_pkg::K1;
            end
            else if (t < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1_pkg::K2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = sha1_pkg::K3;
            end
            tmp = rotl(a, 5) + f + e + k + wt;
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = tmp;
        end
        hash_h[0] += a;
        hash_h[1] += b;
        hash_h[2] += c;
        hash_h[3] += d;
        hash_h[4] += e;
    endfunction

    // Pad the message, run the final block or two and queue the digest.
    function automatic void close_message();
        int pos;
        sha1_pkg::digest_word_t entry;
        pos = int'(msg_bits[8:3]);
        block_bytes[pos] = sha1_pkg::PAD_BYTE;
        pos++;
        if (pos > PAD_LEN_POS)
        begin
            while (pos < 64)
            begin
                block_bytes[pos] = 8'h00;
                pos++;
            end
            run_rounds();
            pos = 0;
        end
        while (pos < PAD_LEN_POS)
        begin
            block_bytes[pos] = 8'h00;
            pos++;
        end
        for (int i = 0; i < 8; i++)
            block_bytes[PAD_LEN_POS + i] = msg_bits[63 - 8*i -: 8];
        run_rounds();
        for (int i = 0; i < 5; i++)
        begin
            entry.digest_word = hash_h[i];
            entry.word_index  = 3'(i);
            entry.last_word   = (3'(i) == sha1_pkg::DIGEST_LAST);
            due_digests       = {due_digests, entry};
        end
        load_initial();
    endfunction

    // One accepted message word: store the byte, compress a full block.
    function automatic void take_word(input sha1_pkg::msg_word_t w);
        int pos;
        if (w.byte_present)
        begin
            pos = int'(msg_bits[8:3]);
            block_bytes[pos] = w.data_byte;
            msg_bits += 64'd8;
            if (pos == 63)
                run_rounds();
        end
        if (w.is_last)
            close_message();
    endfunction

    // Compare one accepted digest word against the oldest prediction.
    function automatic void check_digest(input sha1_pkg::digest_word_t got);
        sha1_pkg::digest_word_t want;
        if (due_digests.size() == 0)
        begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
                $display("%0t: digest word %h idx %0d last %0b with none due",
                         $realtime, got.digest_word, got.word_index, got.last_word);
            return;
        end
        want = due_digests.pop_front();
        if (got.digest_word !== want.digest_word || got.word_index !== want.word_index ||
            got.last_word !== want.last_word)
        begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
                $display("%0t: digest mismatch: expected %h idx %0d last %0b, %s",
                         $realtime, want.digest_word, want.word_index, want.last_word,
                         $sformatf("got %h idx %0d last %0b", got.digest_word,
                                   got.word_index, got.last_word));
        end
    endfunction

    // Sample both channels at the clock edge.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            load_initial();
            due_digests.delete();
        end
        else
        begin
            if (digest_valid && !digest_stall)
                check_digest(digest);
            if (msg_valid && !msg_stall)
                take_word(msg);
        end
        outstanding <= due_digests.size();
        mismatches  <= fail_count;
    end

endmodule

>>> bench/sha1_message_hash_core_tb.sv
// ============================================================================
// SHA-1 message hash core testbench
// Feeds messages byte by byte through the hash core with random bursts and
// gaps on the message side and random stalls on the digest side. A separate
// checker predicts every digest and reports mismatches.
// ============================================================================

module sha1_message_hash_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_WORDS = 130;
    localparam int DRAIN_CYCLES = 200;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   msg_valid = 1'b0;
    logic                   msg_stall;
    sha1_pkg::msg_word_t    msg = '0;
    logic                   digest_valid;
    logic                   digest_stall = 1'b0;
    sha1_pkg::digest_word_t digest;
    int                     mismatches;
    int                     outstanding;

    int           cycle_count = 0;
    int           burst_left = 0;
    int           stall_mode = 0;
    int           stall_timer = 0;

    always #6 clk = ~clk;

    sha1_message_hash_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_stall    (msg_stall),
        .msg          (msg),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest       (digest)
    );

    sha1_digest_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_stall    (msg_stall),
        .msg          (msg),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest       (digest),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    // Guard against a hung core.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** sha1_message_hash_core: FAILED **");
            $finish;
        end
    end

    // Digest side stall: modes change when a random timer runs out, from none
    // through sparse and heavy random stalls to long regular runs.
    always @(posedge clk)
    begin
        if (stall_timer == 0)
        begin
            stall_mode  <= $urandom_range(0, 3);
            stall_timer <= $urandom_range(10, 60);
        end
        else
            stall_timer <= stall_timer - 1;
        case (stall_mode)
            0: digest_stall <= 1'b0;
            1: digest_stall <= ($urandom_range(0, 3) == 0);
            2: digest_stall <= ($urandom_range(0, 3) != 0);
            default: digest_stall <= stall_timer[3];
        endcase
    end

    // Offer one message word, in bursts with random gaps between them,
    // and return at the edge where it is taken.
    task automatic put_word(input logic [7:0] b, input logic present, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                msg_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        msg       <= sha1_pkg::msg_word_t'{data_byte: b, byte_present: present,
                                           is_last: last};
        msg_valid <= 1'b1;
        do
            @(posedge clk);
        while (msg_stall);
    endtask

    // Hold off until every digest word due has come out.
    task automatic wait_for_digests();
        msg_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // One whole message of random bytes, with ignored words mixed in.
    // It ends either on its last byte or on a separate word with no byte.
    task automatic send_message(input int len, input bit absent_end, output int taken);
        taken = 0;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                put_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                taken++;
            end
            put_word(8'($urandom_range(0, 255)), 1'b1, !absent_end && (i == len - 1));
            taken++;
        end
        if (absent_end || len == 0)
        begin
            put_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            taken++;
        end
    endtask

    initial
    begin
        int sent;
        int taken;
        int len;
        int pick;
        int msg_count;
        sent = 0;
        msg_count = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: empty message.
        put_word(8'hA5, 1'b0, 1'b1);
        // The classic three-byte message "abc".
        put_word(8'h61, 1'b1, 1'b0);
        put_word(8'h62, 1'b1, 1'b0);
        put_word(8'h63, 1'b1, 1'b1);
        // Byte extremes with an ignored word in the middle.
        put_word(8'h00, 1'b1, 1'b0);
        put_word(8'hFF, 1'b1, 1'b0);
        put_word(8'h3C, 1'b0, 1'b0);
        put_word(8'hFF, 1'b1, 1'b1);
        // A message closed by a word that carries no byte.
        put_word(8'h5A, 1'b1, 1'b0);
        put_word(8'hA5, 1'b1, 1'b0);
        put_word(8'hFF, 1'b0, 1'b1);
        // Another empty message straight after, then a lone pad-valued byte.
        put_word(8'h00, 1'b0, 1'b1);
        put_word(8'h80, 1'b1, 1'b1);
        wait_for_digests();

        // Random messages: mostly short, some crossing a block, and the
        // padding boundaries where one or two extra blocks are needed.
        while (sent < RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 2)
                len = 0;
            else if (pick < 12)
                len = $urandom_range(1, 20);
            else if (pick < 16)
            begin
                case ($urandom_range(0, 4))
                    0: len = 55;
                    1: len = 56;
                    2: len = 57;
                    3: len = 63;
                    default: len = 64;
                endcase
            end
            else
                len = $urandom_range(21, 70);
            send_message(len, ($urandom_range(0, 9) < 3), taken);
            sent += taken;
            msg_count++;
            if (msg_count == 8)
                wait_for_digests();
        end

        // Drain and settle.
        wait_for_digests();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("** sha1_message_hash_core: PASSED **");
        else
            $display("** sha1_message_hash_core: FAILED **");
        $finish;
    end

endmodule
